@@ hdl/rar_pkg.sv @@
// Shared types, widths and codes for the rational arithmetic reduce block.
package rar_pkg;

    // Operand field width and derived internal widths
    localparam int OPW   = 16;              // operand field width
    localparam int MAGW  = OPW;             // magnitude of an OPW-bit two's complement value
    localparam int PRODW = 2 * MAGW;        // product of two magnitudes
    localparam int SUMW  = PRODW + 1;       // sum of two products
    localparam int CNTW  = $clog2(SUMW);    // divider bit count / gcd shift count
    localparam int RNW   = 33;              // result numerator field
    localparam int RDW   = 32;              // result denominator field

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_LT  = 3'd4,
        OP_GT  = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_P1,
        MS_P2,
        MS_P3
    } t_mstep;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_CHK,
        S_GCD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic   load;
        t_mstep mul_step;
        logic   comb;
        logic   gcd_step;
        logic   div_init;
        logic   div_step;
        logic   finish;
    } t_cmd;

    typedef struct packed {
        logic triv;       // result settled without reduction
        logic gcd_done;
        logic div_last;
    } t_stat;

endpackage

@@ hdl/rar_ctrl.sv @@
// Sequencer for the rational arithmetic reduce block: handshakes and step control.
module rar_ctrl import rar_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output logic  o_stall,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_step = MS_NONE;
        n_valid        = r_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_step = MS_P1;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_step = MS_P2;
                n_state        = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul_step = MS_P3;
                n_state        = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                n_state = i_stat.triv ? S_OUT : S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!r_valid || !i_stall) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

@@ hdl/rar_dpath.sv @@
// Datapath for the rational arithmetic reduce block: products, gcd, dividers, result register.
module rar_dpath import rar_pkg::*; (
    input  logic                   i_clk,
    input  t_cmd                   i_cmd,
    input  logic [2:0]             i_opcode,
    input  logic signed [OPW-1:0]  i_a_numerator,
    input  logic signed [OPW-1:0]  i_a_denominator,
    input  logic signed [OPW-1:0]  i_b_numerator,
    input  logic signed [OPW-1:0]  i_b_denominator,
    output t_stat                  o_stat,
    output logic signed [RNW-1:0]  o_result_numerator,
    output logic [RDW-1:0]         o_result_denominator,
    output logic                   o_compare_true,
    output logic                   o_divide_by_zero
);

    // operand sign/magnitude
    t_opcode          r_opc;
    logic             r_an_neg, r_bn_neg;
    logic [MAGW-1:0]  r_an, r_ad, r_bn, r_bd;
    logic [MAGW-1:0]  n_an, n_ad, n_bn, n_bd;
    logic             n_an_neg, n_bn_neg;

    // products
    logic [PRODW-1:0] r_p1, r_p2, r_p3;
    logic [MAGW-1:0]  mul_x, mul_y;
    logic [PRODW-1:0] mul_p;

    // combined fraction and settled results
    logic             r_num_neg;
    logic [SUMW-1:0]  r_num, r_den;
    logic             r_triv;
    logic [RNW-1:0]   r_t_rn;
    logic [RDW-1:0]   r_t_rd;
    logic             r_t_cmp, r_t_dz;

    // gcd and divider
    logic [SUMW-1:0]  r_u, r_v, r_g;
    logic [CNTW-1:0]  r_k, r_cnt;
    logic [SUMW-1:0]  r_q   [2];
    logic [SUMW-1:0]  r_rem [2];

    // output register
    logic [RNW-1:0]   r_o_rn;
    logic [RDW-1:0]   r_o_rd;
    logic             r_o_cmp, r_o_dz;

    // ---- operand load: move denominator signs into numerators
    always_comb begin
        logic an_s, ad_s, bn_s, bd_s;
        an_s = i_a_numerator[OPW-1];
        ad_s = i_a_denominator[OPW-1];
        bn_s = i_b_numerator[OPW-1];
        bd_s = i_b_denominator[OPW-1];
        n_an = an_s ? MAGW'(-i_a_numerator)   : MAGW'(i_a_numerator);
        n_ad = ad_s ? MAGW'(-i_a_denominator) : MAGW'(i_a_denominator);
        n_bn = bn_s ? MAGW'(-i_b_numerator)   : MAGW'(i_b_numerator);
        n_bd = bd_s ? MAGW'(-i_b_denominator) : MAGW'(i_b_denominator);
        n_an_neg = (an_s ^ ad_s) && (n_an != '0);
        n_bn_neg = (bn_s ^ bd_s) && (n_bn != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opc    <= t_opcode'(i_opcode);
            r_an     <= n_an;
            r_ad     <= n_ad;
            r_bn     <= n_bn;
            r_bd     <= n_bd;
            r_an_neg <= n_an_neg;
            r_bn_neg <= n_bn_neg;
        end
    end

    // ---- shared multiplier, one product per step
    always_comb begin
        unique case (i_cmd.mul_step)
            MS_P1: begin
                mul_x = r_an;
                mul_y = (r_opc == OP_MUL) ? r_bn : r_bd;
            end
            MS_P2: begin
                mul_x = r_bn;
                mul_y = r_ad;
            end
            MS_P3: begin
                mul_x = r_ad;
                mul_y = (r_opc == OP_DIV) ? r_bn : r_bd;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = PRODW'(mul_x) * PRODW'(mul_y);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.mul_step)
            MS_P1:   r_p1 <= mul_p;
            MS_P2:   r_p2 <= mul_p;
            MS_P3:   r_p3 <= mul_p;
            default: ;
        endcase
    end

    // ---- combine products into one fraction or a compare outcome
    logic            c_ca_neg, c_cb_neg, c_cb_sub, c_yneg;
    logic [SUMW-1:0] c_xm, c_ym, c_sum_m;
    logic            c_sum_neg;
    logic            c_num_neg, c_a_lt_b, c_b_lt_a, c_opc_ok, c_opd_zero;
    logic [SUMW-1:0] c_num;

    always_comb begin
        c_ca_neg = r_an_neg && (r_p1 != '0);
        c_cb_neg = r_bn_neg && (r_p2 != '0);
        c_cb_sub = (r_p2 != '0) && !c_cb_neg;
        c_yneg   = (r_opc == OP_SUB) ? c_cb_sub : c_cb_neg;
        c_xm     = SUMW'(r_p1);
        c_ym     = SUMW'(r_p2);
        if (c_ca_neg == c_yneg) begin
            c_sum_m   = c_xm + c_ym;
            c_sum_neg = c_ca_neg;
        end else if (c_xm >= c_ym) begin
            c_sum_m   = c_xm - c_ym;
            c_sum_neg = c_ca_neg;
        end else begin
            c_sum_m   = c_ym - c_xm;
            c_sum_neg = c_yneg;
        end
        if (c_sum_m == '0) begin
            c_sum_neg = 1'b0;
        end

        // exact compare of the cross products
        if (c_ca_neg != c_cb_neg) begin
            c_a_lt_b = c_ca_neg;
            c_b_lt_a = c_cb_neg;
        end else if (c_ca_neg) begin
            c_a_lt_b = r_p1 > r_p2;
            c_b_lt_a = r_p2 > r_p1;
        end else begin
            c_a_lt_b = r_p1 < r_p2;
            c_b_lt_a = r_p2 < r_p1;
        end

        if (r_opc == OP_MUL || r_opc == OP_DIV) begin
            c_num     = SUMW'(r_p1);
            c_num_neg = (r_p1 != '0) && (r_an_neg ^ r_bn_neg);
        end else begin
            c_num     = c_sum_m;
            c_num_neg = c_sum_neg;
        end

        c_opc_ok   = (r_opc == OP_ADD) || (r_opc == OP_SUB) || (r_opc == OP_MUL) ||
                     (r_opc == OP_DIV) || (r_opc == OP_LT)  || (r_opc == OP_GT);
        c_opd_zero = (r_ad == '0) || (r_bd == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comb) begin
            r_num_neg <= c_num_neg;
            r_num     <= c_num;
            r_den     <= SUMW'(r_p3);
            r_u       <= c_num;
            r_v       <= SUMW'(r_p3);
            r_k       <= '0;
            r_t_rn    <= '0;
            r_t_rd    <= '0;
            r_t_cmp   <= 1'b0;
            r_t_dz    <= 1'b0;
            r_triv    <= 1'b1;
            if (!c_opc_ok) begin
                // unused opcode: all zero
            end else if (c_opd_zero) begin
                r_t_dz <= 1'b1;
            end else if (r_opc == OP_LT) begin
                r_t_cmp <= c_a_lt_b;
            end else if (r_opc == OP_GT) begin
                r_t_cmp <= c_b_lt_a;
            end else if (r_p3 == '0) begin
                r_t_dz <= 1'b1;     // divide by zero-valued b
            end else if (c_num == '0) begin
                r_t_rd <= {{(RDW-1){1'b0}}, 1'b1};
            end else begin
                r_triv <= 1'b0;
            end
        end else if (i_cmd.gcd_step) begin
            // binary gcd, one step per cycle
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= r_v;
                r_v <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
    end

    // ---- two-lane restoring divider: numerator and denominator by the gcd
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_g      <= r_u << r_k;
            r_cnt    <= '0;
            r_q[0]   <= r_num;
            r_q[1]   <= r_den;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            for (int l = 0; l < 2; l++) begin
                logic [SUMW:0] sh;
                logic          ge;
                sh = {r_rem[l], r_q[l][SUMW-1]};
                ge = sh >= {1'b0, r_g};
                r_rem[l] <= ge ? SUMW'(sh - {1'b0, r_g}) : SUMW'(sh);
                r_q[l]   <= {r_q[l][SUMW-2:0], ge};
            end
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_triv) begin
                r_o_rn  <= r_t_rn;
                r_o_rd  <= r_t_rd;
                r_o_cmp <= r_t_cmp;
                r_o_dz  <= r_t_dz;
            end else begin
                r_o_rn  <= r_num_neg ? RNW'(-r_q[0]) : RNW'(r_q[0]);
                r_o_rd  <= RDW'(r_q[1]);
                r_o_cmp <= 1'b0;
                r_o_dz  <= 1'b0;
            end
        end
    end

    assign o_stat.triv     = r_triv;
    assign o_stat.gcd_done = (r_v == '0);
    assign o_stat.div_last = (r_cnt == CNTW'(SUMW - 1));

    assign o_result_numerator   = signed'(r_o_rn);
    assign o_result_denominator = r_o_rd;
    assign o_compare_true       = r_o_cmp;
    assign o_divide_by_zero     = r_o_dz;

endmodule

@@ hdl/rational_arith_reduce.sv @@
// Top level of the rational arithmetic reduce block.
// Takes one item at a time: an opcode (add, subtract, multiply, divide,
// less-than, greater-than) and two signed 16-bit fractions. Each operand's
// denominator sign is moved into its numerator; arithmetic results come back
// reduced by their gcd with a positive denominator (zero reduces to 0/1),
// compares give an exact compare_true with a zero fraction, and any zero
// operand denominator, or division by a zero-valued b, raises divide_by_zero
// with the other fields zero. Unused opcodes give an all-zero result.
// Sequence: the products go through one shared 16x16 multiplier one after
// another, then a combine state and a check state. Compares, zero results
// and error cases then go straight to the output state. Reduced results add
// a binary gcd that does one shift or subtract per cycle. Each shift drops
// one bit from the pair and each subtract is followed by at least one shift,
// so the gcd steps are bounded by the bits of a 32-bit numerator and a
// 31-bit denominator. A two-lane restoring divider then divides numerator
// and denominator by the gcd together. o_stall is high from acceptance until
// the result is moved into the output register; that register lets the next
// item be taken while a finished result still waits on i_stall.
module rational_arith_reduce import rar_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input item channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [2:0]             i_opcode,
    input  logic signed [OPW-1:0]  i_a_numerator,
    input  logic signed [OPW-1:0]  i_a_denominator,
    input  logic signed [OPW-1:0]  i_b_numerator,
    input  logic signed [OPW-1:0]  i_b_denominator,
    // result item channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [RNW-1:0]  o_result_numerator,
    output logic [RDW-1:0]         o_result_denominator,
    output logic                   o_compare_true,
    output logic                   o_divide_by_zero
);

    t_cmd  cmd;
    t_stat stat;

    rar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    rar_dpath u_dpath (
        .i_clk                (i_clk),
        .i_cmd                (cmd),
        .i_opcode             (i_opcode),
        .i_a_numerator        (i_a_numerator),
        .i_a_denominator      (i_a_denominator),
        .i_b_numerator        (i_b_numerator),
        .i_b_denominator      (i_b_denominator),
        .o_stat               (stat),
        .o_result_numerator   (o_result_numerator),
        .o_result_denominator (o_result_denominator),
        .o_compare_true       (o_compare_true),
        .o_divide_by_zero     (o_divide_by_zero)
    );

endmodule

@@ tb/sv/rational_arith_reduce_test.sv @@
// Self-checking testbench for rational_arith_reduce: directed and random fraction items.
`timescale 1ns / 100ps

module rational_arith_reduce_test;
    import rar_pkg::*;

    // Opcodes that the package does not name; the block must answer them with all zeros.
    localparam logic [2:0] OPC_SPARE6 = 3'd6;
    localparam logic [2:0] OPC_SPARE7 = 3'd7;

    localparam int  CLK_HALF_NS    = 5;
    localparam int  RESET_CYCLES   = 4;
    localparam int  RANDOM_ITEMS   = 1900;
    localparam int  CALM_TAIL      = 120;      // last items sent with no idling on either side
    localparam int  HOLD_AT_ITEM   = 300;      // receiver's long hold-off starts here
    localparam int  HOLD_CYCLES    = 600;
    localparam int  DRAIN_CYCLES   = 200;      // well past the worst item latency
    localparam int  TIMEOUT_NS     = 15_000_000;

    // One operand pair plus opcode, as put on the input ports.
    typedef struct {
        logic [2:0]     opc;
        logic [OPW-1:0] an;
        logic [OPW-1:0] ad;
        logic [OPW-1:0] bn;
        logic [OPW-1:0] bd;
    } t_operands;

    // Expected fields of one result item.
    typedef struct {
        logic signed [RNW-1:0] num;
        logic [RDW-1:0]        den;
        logic                  cmp;
        logic                  dz;
    } t_fraction_result;

    // Sign and magnitude; 64-bit magnitudes hold every product without overflow.
    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } t_signmag;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_opcode = '0;
    logic signed [OPW-1:0] i_a_numerator = '0;
    logic signed [OPW-1:0] i_a_denominator = '0;
    logic signed [OPW-1:0] i_b_numerator = '0;
    logic signed [OPW-1:0] i_b_denominator = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [RNW-1:0] o_result_numerator;
    logic [RDW-1:0]        o_result_denominator;
    logic                  o_compare_true;
    logic                  o_divide_by_zero;

    t_operands        pending_items[$];     // filled by the stimulus block, drained by the driver
    t_fraction_result fraction_expect[$];   // predictions, oldest first

    int  n_accepted = 0;    // written by the driver only, NBA so other blocks see it cleanly
    int  n_checked = 0;
    int  n_errors = 0;
    int  n_arith = 0;
    int  n_compare = 0;
    int  n_spare = 0;
    int  n_zero_den = 0;
    bit  calm_tail = 1'b0;

    rational_arith_reduce u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_opcode             (i_opcode),
        .i_a_numerator        (i_a_numerator),
        .i_a_denominator      (i_a_denominator),
        .i_b_numerator        (i_b_numerator),
        .i_b_denominator      (i_b_denominator),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_result_numerator   (o_result_numerator),
        .o_result_denominator (o_result_denominator),
        .o_compare_true       (o_compare_true),
        .o_divide_by_zero     (o_divide_by_zero)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Fraction predictor
    // ------------------------------------------------------------------

    // Two's complement operand field to sign/magnitude (-2^(OPW-1) keeps its full magnitude).
    function automatic t_signmag to_signmag(logic [OPW-1:0] raw);
        t_signmag       r;
        logic [OPW-1:0] pos;
        pos   = ~raw + 1'b1;
        r.neg = raw[OPW-1];
        r.mag = r.neg ? 64'(pos) : 64'(raw);
        return r;
    endfunction

    function automatic t_signmag sm_product(t_signmag x, t_signmag y);
        t_signmag r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic t_signmag sm_sum(t_signmag x, t_signmag y);
        t_signmag r;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end else begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    // True when x < y; zero always carries a clear sign, so -0 never shows up.
    function automatic bit sm_below(t_signmag x, t_signmag y);
        if (x.neg != y.neg) return x.neg;
        if (x.neg) return x.mag > y.mag;
        return x.mag < y.mag;
    endfunction

    // Euclid; both arguments nonzero here.
    function automatic logic [63:0] gcd_of(logic [63:0] u, logic [63:0] v);
        logic [63:0] t;
        while (v != 0) begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    function automatic t_fraction_result predict_fraction(t_operands op);
        t_fraction_result r;
        t_signmag         an, ad, bn, bd, xa, xb, num, den;
        logic [63:0]      g, q, q_signed, d_red;
        r.num = '0;
        r.den = '0;
        r.cmp = 1'b0;
        r.dz  = 1'b0;
        an = to_signmag(op.an);
        ad = to_signmag(op.ad);
        bn = to_signmag(op.bn);
        bd = to_signmag(op.bd);
        // denominator sign moves into the numerator
        if (ad.neg) begin
            an.neg = !an.neg;
            ad.neg = 1'b0;
        end
        if (bd.neg) begin
            bn.neg = !bn.neg;
            bd.neg = 1'b0;
        end
        if (an.mag == 0) an.neg = 1'b0;
        if (bn.mag == 0) bn.neg = 1'b0;

        if (op.opc > OP_GT) return r;
        if (ad.mag == 0 || bd.mag == 0) begin
            r.dz = 1'b1;
            return r;
        end

        xa = sm_product(an, bd);
        xb = sm_product(bn, ad);
        if (op.opc == OP_LT) begin
            r.cmp = sm_below(xa, xb);
            return r;
        end
        if (op.opc == OP_GT) begin
            r.cmp = sm_below(xb, xa);
            return r;
        end

        den.neg = 1'b0;
        den.mag = ad.mag * bd.mag;
        case (op.opc)
            OP_ADD: begin
                num = sm_sum(xa, xb);
            end
            OP_SUB: begin
                xb.neg = (xb.mag != 0) && !xb.neg;
                num    = sm_sum(xa, xb);
            end
            OP_MUL: begin
                num = sm_product(an, bn);
            end
            default: begin
                // a/b = (an*bd) / (ad*bn), sign from the two numerators
                num     = xa;
                num.neg = (num.mag != 0) && (an.neg != bn.neg);
                den.mag = ad.mag * bn.mag;
            end
        endcase

        if (den.mag == 0) begin
            r.dz = 1'b1;
        end else if (num.mag == 0) begin
            r.den = 1;
        end else begin
            g        = gcd_of(num.mag, den.mag);
            q        = num.mag / g;
            q_signed = num.neg ? (64'd0 - q) : q;
            d_red    = den.mag / g;
            r.num    = q_signed[RNW-1:0];
            r.den    = d_red[RDW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_item(logic [2:0] opc, int an, int ad, int bn, int bd);
        t_operands it;
        it.opc = opc;
        it.an  = an[OPW-1:0];
        it.ad  = ad[OPW-1:0];
        it.bn  = bn[OPW-1:0];
        it.bd  = bd[OPW-1:0];
        pending_items.push_back(it);
    endfunction

    // Mix of extremes, small values (zero denominators come up often) and full-range values.
    function automatic int pick_operand();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = -(2 ** (OPW - 1));
                    1:       v = 2 ** (OPW - 1) - 1;
                    2:       v = 0;
                    3:       v = 1;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = int'($urandom_range(0, 16)) - 8;
            default: v = int'($urandom_range(0, 2 ** OPW - 1));
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pick_opcode();
        int sel;
        sel = $urandom_range(0, 59);
        if (sel == 0) return OPC_SPARE6;
        if (sel == 1) return OPC_SPARE7;
        return 3'(sel % 6);
    endfunction

    initial begin : build_stimulus
        int k;
        // directed part
        queue_item(OP_ADD, 1, 2, 1, 3);                 // 5/6
        queue_item(OP_SUB, 1, 2, 1, 2);                 // zero result reduces to 0/1
        queue_item(OP_MUL, -32768, -1, -32768, -1);     // largest product magnitude
        queue_item(OP_MUL, -32768, 1, 32767, 1);        // large negative numerator
        queue_item(OP_DIV, 32767, -32768, -32768, 32767);
        queue_item(OP_DIV, -1, -1, -1, -1);             // signs cancel everywhere
        queue_item(OP_LT, 1, 2, 2, 4);                  // equal values: not less
        queue_item(OP_GT, 1, 2, 2, 4);                  // equal values: not greater
        queue_item(OP_LT, -1, 3, 1, 3);
        queue_item(OP_GT, 5, -7, -6, 7);                // negative denominator flips a's sign
        queue_item(OP_GT, 0, -1, 0, 5);                 // zeros of either sign compare equal
        queue_item(OP_ADD, 3, 0, 1, 2);                 // zero denominator on a
        queue_item(OP_LT, 3, 4, 1, 0);                  // zero denominator on b, compare
        queue_item(OP_DIV, 3, 4, 0, -9);                // divide by a zero-valued b
        queue_item(OP_DIV, 7, 0, 0, 5);                 // both error conditions at once
        queue_item(OP_ADD, 0, 0, 0, 0);
        queue_item(OPC_SPARE6, 5, 3, -2, 7);
        queue_item(OPC_SPARE7, -32768, 0, 32767, -1);
        queue_item(OP_ADD, -32768, -32768, -32768, -32768);  // 2/1
        queue_item(OP_SUB, 32767, 1, -32768, 1);
        queue_item(OP_ADD, -32768, 32767, -32768, 32766);    // large coprime denominators
        queue_item(OP_SUB, 1, -32768, 1, 32767);
        queue_item(OP_MUL, 0, -5, 3, 4);
        queue_item(OP_DIV, 0, 1, -3, 5);                // zero over nonzero divisor
        queue_item(OP_SUB, -32768, 1, 32767, 1);        // widest negative difference
        // random part
        for (k = 0; k < RANDOM_ITEMS; k++)
            queue_item(pick_opcode(), pick_operand(), pick_operand(), pick_operand(),
                       pick_operand());
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: holds one item on the ports until it is taken, then
    // either presents the next one in the same edge or idles a burst.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_items
        static int        gap_left = 0;
        t_operands        cur, nxt;
        t_fraction_result exp_r;
        logic             valid_next;
        int               idle_pct;
        cur.opc = i_opcode;
        cur.an  = i_a_numerator;
        cur.ad  = i_a_denominator;
        cur.bn  = i_b_numerator;
        cur.bd  = i_b_denominator;
        valid_next = i_valid;
        // long idle-free stretches every third window of items
        idle_pct = ((n_accepted / 150) % 3 == 2) ? 0 : 30;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                exp_r = predict_fraction(cur);
                fraction_expect.push_back(exp_r);
                n_accepted <= n_accepted + 1;
                if (cur.opc > OP_GT) n_spare++;
                else if (cur.opc == OP_LT || cur.opc == OP_GT) n_compare++;
                else n_arith++;
                if (exp_r.dz) n_zero_den++;
                valid_next = 1'b0;
            end
            if (!valid_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    if (!calm_tail && $urandom_range(0, 99) < idle_pct) begin
                        gap_left = $urandom_range(1, 14) - 1;
                    end else begin
                        nxt = pending_items.pop_front();
                        i_opcode        <= nxt.opc;
                        i_a_numerator   <= nxt.an;
                        i_a_denominator <= nxt.ad;
                        i_b_numerator   <= nxt.bn;
                        i_b_denominator <= nxt.bd;
                        valid_next = 1'b1;
                    end
                end
            end
            calm_tail <= (pending_items.size() < CALM_TAIL);
        end
        i_valid <= valid_next;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off so the output
    // register fills and the block backs up its input, none at the tail.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drain_results
        static int hold_left = 0;
        static int burst_left = 0;
        static bit hold_done = 1'b0;
        int        stall_pct;
        stall_pct = ((n_checked / 170) % 3 == 1) ? 0 : 30;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_stall <= 1'b1;
        end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
            burst_left = $urandom_range(1, 14) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every taken result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_fraction_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (fraction_expect.size() == 0) begin
                $error("result item with none expected: %0d/%0d cmp=%0b dz=%0b",
                       o_result_numerator, o_result_denominator, o_compare_true,
                       o_divide_by_zero);
                n_errors++;
            end else begin
                exp_r = fraction_expect.pop_front();
                n_checked++;
                if (o_result_numerator !== exp_r.num) begin
                    $error("result_numerator: expected %0d, got %0d",
                           exp_r.num, o_result_numerator);
                    n_errors++;
                end
                if (o_result_denominator !== exp_r.den) begin
                    $error("result_denominator: expected %0d, got %0d",
                           exp_r.den, o_result_denominator);
                    n_errors++;
                end
                if (o_compare_true !== exp_r.cmp) begin
                    $error("compare_true: expected %0b, got %0b", exp_r.cmp, o_compare_true);
                    n_errors++;
                end
                if (o_divide_by_zero !== exp_r.dz) begin
                    $error("divide_by_zero: expected %0b, got %0b",
                           exp_r.dz, o_divide_by_zero);
                    n_errors++;
                end
            end
        end
    end

    // End of run: all items sent and all results back, then a quiet drain.
    initial begin : finish_run
        @(posedge i_rst_n);
        while (pending_items.size() != 0 || i_valid || fraction_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fraction_expect.size() != 0) begin
            $error("%0d predicted results never arrived", fraction_expect.size());
            n_errors++;
        end
        $display("ran %0d fraction items: %0d arithmetic, %0d compares, %0d spare opcodes",
                 n_accepted, n_arith, n_compare, n_spare);
        $display("%0d results checked, %0d with a zero denominator, %0d mismatches",
                 n_checked, n_zero_den, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", fraction_expect.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/rar_pkg.sv
hdl/rar_ctrl.sv
hdl/rar_dpath.sv
hdl/rational_arith_reduce.sv
tb/sv/rational_arith_reduce_test.sv
